FILE: rtl/cma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants of the centered moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

	localparam int HALF_W = 4;
	localparam logic [HALF_W-1:0] HALF_RESET = 4'd2;

	// back part status seen by the front part
	typedef struct packed {
		logic queue_empty;
		logic back_idle;
	} back_status_t;

endpackage

FILE: rtl/cma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/cma_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_fifo
// Small register queue; depth is a power of two.
// ----------------------------------------------------------------------------
module cma_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/cma_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_front
// Accepts samples into the sample line and turns each one into result jobs.
// ----------------------------------------------------------------------------
module cma_front import cma_pkg::*; #(
	parameter int MAX_HALF    = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     half_width_we,
	input  logic [HALF_W-1:0]                        half_width,
	input  logic                                     push,
	output logic                                     full,
	input  logic [SAMPLE_BITS-1:0]                   sample,
	input  logic                                     last_sample,
	input  back_status_t                             status,
	output logic                                     ram_we,
	output logic [$clog2(2*MAX_HALF+1)-1:0]          ram_waddr,
	output logic [SAMPLE_BITS-1:0]                   ram_wdata,
	output logic                                     job_push,
	output logic [$clog2(2*MAX_HALF+1)+$clog2(2*MAX_HALF+2):0] job_data,
	input  logic                                     job_full
);

	localparam int LINE_DEPTH = 2 * MAX_HALF + 1;
	localparam int AW         = $clog2(LINE_DEPTH);
	localparam int HW         = $clog2(MAX_HALF + 1);
	localparam int RCW        = $clog2(MAX_HALF + 2);
	localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
	localparam int EW         = (HW > HALF_W) ? HW : HALF_W;

	logic [HALF_W-1:0] half_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     newest_q;
	logic [RCW-1:0]    recv_q;
	logic [HW-1:0]     emit_q;
	logic              last_q;
	logic              busy_q;

	logic              accept;
	logic [HW-1:0]     h_eff;
	logic [HW-1:0]     d;
	logic [HW-1:0]     lead;
	logic [HW-1:0]     r;
	logic              emit_ok;
	logic [AW:0]       span;
	logic [AW:0]       start_ext;
	logic [AW-1:0]     start;
	logic [CNT_W-1:0]  count;

	assign full   = busy_q || !status.queue_empty || !status.back_idle;
	assign accept = push && !full;

	assign ram_we    = accept;
	assign ram_waddr = head_q;
	assign ram_wdata = sample;

	always_comb begin
		if (EW'(half_q) > EW'(MAX_HALF)) begin
			h_eff = HW'(MAX_HALF);
		end else begin
			h_eff = HW'(half_q);
		end
		d       = HW'(recv_q - RCW'(1));
		lead    = (emit_q < h_eff) ? emit_q : h_eff;
		r       = (lead < d) ? lead : d;
		emit_ok = (recv_q != '0) && (last_q || (lead <= d));
		span      = (AW+1)'(d) + (AW+1)'(r);
		start_ext = (AW+1)'(newest_q) + (AW+1)'(LINE_DEPTH) - span;
		if (start_ext >= (AW+1)'(LINE_DEPTH)) begin
			start = AW'(start_ext - (AW+1)'(LINE_DEPTH));
		end else begin
			start = AW'(start_ext);
		end
		count = CNT_W'({r, 1'b1});
	end

	assign job_push = busy_q && emit_ok && !job_full;
	assign job_data = {start, count, last_q && (d == '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= HALF_RESET;
			head_q   <= '0;
			newest_q <= '0;
			recv_q   <= '0;
			emit_q   <= '0;
			last_q   <= 1'b0;
			busy_q   <= 1'b0;
		end else begin
			if (half_width_we) begin
				half_q <= half_width;
			end
			if (accept) begin
				newest_q <= head_q;
				head_q   <= (head_q == AW'(LINE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				recv_q   <= recv_q + 1'b1;
				last_q   <= last_sample;
				busy_q   <= 1'b1;
			end else if (busy_q) begin
				if (emit_ok) begin
					if (!job_full) begin
						recv_q <= recv_q - 1'b1;
						if (emit_q < HW'(MAX_HALF)) begin
							emit_q <= emit_q + 1'b1;
						end
					end
				end else begin
					busy_q <= 1'b0;
					if (last_q) begin
						recv_q <= '0;
						emit_q <= '0;
					end
				end
			end
		end
	end

	// pending samples never outgrow the half window plus the center sample
	a_recv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		recv_q <= RCW'(MAX_HALF + 1))
		else $error("pending sample count out of range");

	// a stream end clears the counters
	a_stream_end: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !emit_ok && last_q |=> (recv_q == '0) && (emit_q == '0))
		else $error("counters not cleared at stream end");

endmodule

FILE: rtl/cma_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_back
// Sums each job's window from the sample line and divides by its count.
// ----------------------------------------------------------------------------
module cma_back #(
	parameter int MAX_HALF      = 8,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     job_empty,
	input  logic [$clog2(2*MAX_HALF+1)+$clog2(2*MAX_HALF+2):0] job_data,
	output logic                                     job_pop,
	output logic                                     ram_re,
	output logic [$clog2(2*MAX_HALF+1)-1:0]          ram_raddr,
	input  logic [SAMPLE_BITS-1:0]                   ram_rdata,
	input  logic                                     res_full,
	output logic                                     res_push,
	output logic [SAMPLE_BITS+FRACTION_BITS:0]       res_data,
	output logic                                     idle
);

	localparam int LINE_DEPTH = 2 * MAX_HALF + 1;
	localparam int AW         = $clog2(LINE_DEPTH);
	localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
	localparam int SUM_W      = SAMPLE_BITS + $clog2(LINE_DEPTH);
	localparam int OUT_W      = SAMPLE_BITS + FRACTION_BITS;
	localparam int NW         = SUM_W + FRACTION_BITS + 2;
	localparam int DW         = CNT_W + 1;
	localparam int SW         = $clog2(OUT_W + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;

	logic [1:0]       state_q;
	logic [AW-1:0]    addr_q;
	logic [CNT_W-1:0] left_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;
	logic             rd_s1;
	logic [SUM_W-1:0] sum_q;
	logic             neg_q;
	logic [DW-1:0]    rem_q;
	logic [OUT_W-1:0] quo_q;
	logic [SW-1:0]    step_q;

	logic [AW-1:0]    job_start;
	logic [CNT_W-1:0] job_count;
	logic             job_last;
	logic [SUM_W-1:0] sample_ext;
	logic [SUM_W-1:0] mag;
	logic [NW-1:0]    n_val;
	logic [DW:0]      sh;
	logic [DW:0]      dvs;
	logic             ge;
	logic [DW:0]      diff;
	logic [OUT_W-1:0] avg;

	assign {job_start, job_count, job_last} = job_data;

	assign idle      = (state_q == ST_IDLE);
	assign job_pop   = idle && !job_empty;
	assign ram_re    = (state_q == ST_SUM) && (left_q != '0);
	assign ram_raddr = addr_q;

	always_comb begin
		sample_ext = {{(SUM_W-SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
		mag   = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
		n_val = (NW'(mag) << (FRACTION_BITS + 1)) + NW'(cnt_q);
		sh    = {rem_q, quo_q[OUT_W-1]};
		dvs   = (DW+1)'({cnt_q, 1'b0});
		ge    = (sh >= dvs);
		diff  = sh - dvs;
		avg   = neg_q ? (~quo_q + 1'b1) : quo_q;
	end

	assign res_push = (state_q == ST_PUSH) && !res_full;
	assign res_data = {avg, last_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_s1   <= 1'b0;
			left_q  <= '0;
			step_q  <= '0;
		end else begin
			rd_s1 <= ram_re;
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						addr_q  <= job_start;
						left_q  <= job_count;
						cnt_q   <= job_count;
						last_q  <= job_last;
						sum_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (ram_re) begin
						addr_q <= (addr_q == AW'(LINE_DEPTH - 1)) ? '0 : addr_q + 1'b1;
						left_q <= left_q - 1'b1;
					end
					if (rd_s1) begin
						sum_q <= sum_q + sample_ext;
					end else if (left_q == '0) begin
						neg_q   <= sum_q[SUM_W-1];
						rem_q   <= DW'(n_val >> OUT_W);
						quo_q   <= OUT_W'(n_val);
						step_q  <= SW'(OUT_W);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= ge ? DW'(diff) : DW'(sh);
					quo_q  <= {quo_q[OUT_W-2:0], ge};
					step_q <= step_q - 1'b1;
					if (step_q == SW'(1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < {cnt_q, 1'b0}))
		else $error("division remainder out of range");

	// a result leaves only after every quotient bit is done
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (step_q == '0) && !rd_s1)
		else $error("result pushed before division finished");

endmodule

FILE: rtl/centered_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_moving_average
// Centered moving average with windows that shrink at both stream edges.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: push / full with sample and last_sample; an item is taken
//   when push is high and full is low. last_sample closes the stream and
//   flushes all of its remaining results.
//   result channel: empty / pop with average (signed Q15.8) and last_result;
//   the oldest result sits on the ports while empty is low.
//   the user must write half_width through half_width_we only while the block is idle; the block does not enforce it.
// Timing:
//   each result in the back part takes one sample-line read per window tap
//   and one quotient bit per cycle of the shared divider.
//   a new item is taken once every result of the previous one has been
//   computed.
//   a stalled receiver only blocks once the result queue fills.
// Reset:
//   arst_n clears queues and counters and sets half_width to 2; no sweep of
//   the sample line is needed.
// ----------------------------------------------------------------------------
module centered_moving_average import cma_pkg::*; #(
	parameter int MAX_HALF      = 8,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   half_width_we,
	input  logic [HALF_W-1:0]                      half_width,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [SAMPLE_BITS-1:0]          sample,
	input  logic                                   last_sample,
	output logic                                   empty,
	input  logic                                   pop,
	output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] average,
	output logic                                   last_result
);

	localparam int LINE_DEPTH = 2 * MAX_HALF + 1;
	localparam int AW         = $clog2(LINE_DEPTH);
	localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
	localparam int JOB_W      = AW + CNT_W + 1;
	localparam int OUT_W      = SAMPLE_BITS + FRACTION_BITS;
	localparam int RES_W      = OUT_W + 1;
	localparam int JOB_DEPTH  = 4;
	localparam int RES_DEPTH  = 4;

	back_status_t     status;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [SAMPLE_BITS-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic             job_push;
	logic [JOB_W-1:0] job_in;
	logic             job_full;
	logic             job_pop;
	logic [JOB_W-1:0] job_out;
	logic             job_empty;
	logic             res_push;
	logic [RES_W-1:0] res_in;
	logic             res_full;
	logic [RES_W-1:0] res_out;
	logic             back_idle;

	assign status.queue_empty = job_empty;
	assign status.back_idle   = back_idle;

	cma_front #(
		.MAX_HALF    (MAX_HALF),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.half_width_we (half_width_we),
		.half_width    (half_width),
		.push          (push),
		.full          (full),
		.sample        (sample),
		.last_sample   (last_sample),
		.status        (status),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.job_push      (job_push),
		.job_data      (job_in),
		.job_full      (job_full)
	);

	cma_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (LINE_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cma_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	cma_back #(
		.MAX_HALF      (MAX_HALF),
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job_data  (job_out),
		.job_pop   (job_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_in),
		.idle      (back_idle)
	);

	cma_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign average     = res_out[RES_W-1:1];
	assign last_result = res_out[0];

endmodule
